>>> hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk with rst_n as the disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("av sync assertion failed");

// Next-cycle implication.
`define AVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("av sync assertion failed");

`endif

>>> hw/rtl/avs_pkg.sv
`default_nettype none

package avs_pkg;

    localparam int CHANNELS = 4;
    localparam int CHAN_CMP_W = ($clog2(CHANNELS + 1) > 2) ? $clog2(CHANNELS + 1) : 2;

    localparam int CFG_AW = 5;
    localparam int CFG_IDX_W = CFG_AW - 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_BACK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_COOLDOWN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_DRIFT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_COOLDOWN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_END       = 3'd7;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_FINISHED = 1'b1;

    localparam logic [31:0] WRAP_PREV_MIN  = 32'd1000;
    localparam logic [30:0] WRAP_PTS_MAX   = 31'd100;
    localparam logic [32:0] WRAP_IGNORE_MS = 33'd1000;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         channel;
        logic               channel_active;
        logic [31:0]        now_ms;
        logic               audio_valid;
        logic [30:0]        audio_clock_ms;
        logic signed [31:0] frame_pts_ms;
        logic signed [31:0] duration_ms;
    } avs_item_t;

    typedef struct packed {
        logic               resume_video;
        logic               pause_video;
        logic               seek_video;
        logic signed [31:0] seek_target_ms;
        logic               restart_audio;
    } avs_result_t;

    typedef struct packed {
        logic [15:0] drift_limit_ms;
        logic [15:0] resume_margin_ms;
        logic [15:0] check_period_ms;
        logic [15:0] seek_back_ms;
        logic [15:0] seek_cooldown_ms;
        logic [15:0] large_drift_ms;
        logic [15:0] long_cooldown_ms;
        logic [15:0] near_end_margin_ms;
    } avs_cfg_t;

    typedef struct packed {
        logic [31:0] prev_pts;
        logic [31:0] last_check_time;
        logic [31:0] last_correct_time;
        logic        initial_sync_done;
        logic        video_paused;
        logic [32:0] ignore_wrap_until;
    } avs_chan_t;

    localparam avs_cfg_t CFG_RESET = '{
        drift_limit_ms:     16'd400,
        resume_margin_ms:   16'd120,
        check_period_ms:    16'd20,
        seek_back_ms:       16'd100,
        seek_cooldown_ms:   16'd300,
        large_drift_ms:     16'd2000,
        long_cooldown_ms:   16'd1200,
        near_end_margin_ms: 16'd10000
    };

endpackage

`default_nettype wire

>>> hw/rtl/avs_in_if.sv
`default_nettype none

interface avs_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [1:0]         channel;
    logic               channel_active;
    logic [31:0]        now_ms;
    logic               audio_valid;
    logic [30:0]        audio_clock_ms;
    logic signed [31:0] frame_pts_ms;
    logic signed [31:0] duration_ms;

    modport source (
        output valid, cmd, channel, channel_active, now_ms, audio_valid,
               audio_clock_ms, frame_pts_ms, duration_ms,
        input  ready
    );

    modport sink (
        input  valid, cmd, channel, channel_active, now_ms, audio_valid,
               audio_clock_ms, frame_pts_ms, duration_ms,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/avs_out_if.sv
`default_nettype none

interface avs_out_if;
    logic               valid;
    logic               ready;
    logic               resume_video;
    logic               pause_video;
    logic               seek_video;
    logic signed [31:0] seek_target_ms;
    logic               restart_audio;

    modport source (
        output valid, resume_video, pause_video, seek_video, seek_target_ms,
               restart_audio,
        input  ready
    );

    modport sink (
        input  valid, resume_video, pause_video, seek_video, seek_target_ms,
               restart_audio,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/avs_cfg_regs.sv
`default_nettype none

module avs_cfg_regs
    import avs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output avs_cfg_t               cfg
);

    avs_cfg_t             cfg_reg;
    avs_cfg_t             cfg_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [15:0]          rd_val;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SYNC_THRESHOLD: cfg_next.drift_limit_ms     = pwdata[15:0];
                REG_RESUME_MARGIN:  cfg_next.resume_margin_ms   = pwdata[15:0];
                REG_CHECK_PERIOD:   cfg_next.check_period_ms    = pwdata[15:0];
                REG_SEEK_BACK:      cfg_next.seek_back_ms       = pwdata[15:0];
                REG_SEEK_COOLDOWN:  cfg_next.seek_cooldown_ms   = pwdata[15:0];
                REG_LARGE_DRIFT:    cfg_next.large_drift_ms     = pwdata[15:0];
                REG_LONG_COOLDOWN:  cfg_next.long_cooldown_ms   = pwdata[15:0];
                REG_NEAR_END:       cfg_next.near_end_margin_ms = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SYNC_THRESHOLD: rd_val = cfg_reg.drift_limit_ms;
            REG_RESUME_MARGIN:  rd_val = cfg_reg.resume_margin_ms;
            REG_CHECK_PERIOD:   rd_val = cfg_reg.check_period_ms;
            REG_SEEK_BACK:      rd_val = cfg_reg.seek_back_ms;
            REG_SEEK_COOLDOWN:  rd_val = cfg_reg.seek_cooldown_ms;
            REG_LARGE_DRIFT:    rd_val = cfg_reg.large_drift_ms;
            REG_LONG_COOLDOWN:  rd_val = cfg_reg.long_cooldown_ms;
            REG_NEAR_END:       rd_val = cfg_reg.near_end_margin_ms;
            default:            rd_val = 16'd0;
        endcase
        prdata = {16'd0, rd_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/avs_state_store.sv
`default_nettype none

module avs_state_store
    import avs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic [1:0] channel,
    output avs_chan_t      rd_state,
    input  wire logic      wr_en,
    input  wire avs_chan_t wr_state
);

    avs_chan_t chan_reg [CHANNELS];
    avs_chan_t chan_next [CHANNELS];

    always_comb
    begin
        rd_state = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (CHAN_CMP_W'(channel) == CHAN_CMP_W'(c))
            begin
                rd_state = chan_reg[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_next[c] = chan_reg[c];
            if (wr_en && (CHAN_CMP_W'(channel) == CHAN_CMP_W'(c)))
            begin
                chan_next[c] = wr_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_reg[c] <= chan_next[c];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/avs_decide.sv
`default_nettype none

module avs_decide
    import avs_pkg::*;
(
    input  wire avs_item_t item,
    input  wire avs_chan_t st,
    input  wire avs_cfg_t  cfg,
    output avs_result_t    res,
    output avs_chan_t      st_next,
    output logic           st_we
);

    function automatic logic signed [33:0] ext16(input logic [15:0] v);
        ext16 = $signed({18'd0, v});
    endfunction

    logic                in_range;
    logic [30:0]         pts_c;
    logic signed [33:0]  diff;
    logic signed [33:0]  since_check;
    logic signed [33:0]  since_corr;
    logic signed [33:0]  dur_s;
    logic                resume_ok;
    logic                wrap;
    logic                ign_active;
    logic                check_due;
    logic                over;
    logic [15:0]         cool;
    logic                cooling;
    logic                end_zone;
    logic signed [31:0]  target;

    assign in_range    = CHAN_CMP_W'(item.channel) < CHAN_CMP_W'(CHANNELS);
    assign pts_c       = item.frame_pts_ms[31] ? 31'd0 : item.frame_pts_ms[30:0];
    assign diff        = $signed({3'd0, item.audio_clock_ms}) - $signed({3'd0, pts_c});
    assign since_check = $signed({2'd0, item.now_ms}) - $signed({2'd0, st.last_check_time});
    assign since_corr  = $signed({2'd0, item.now_ms})
                       - $signed({2'd0, st.last_correct_time});
    assign dur_s       = {{2{item.duration_ms[31]}}, item.duration_ms};
    assign resume_ok   = diff >= -ext16(cfg.resume_margin_ms);
    assign wrap        = (st.prev_pts > WRAP_PREV_MIN) && (pts_c < WRAP_PTS_MAX);
    assign ign_active  = (st.ignore_wrap_until != 33'd0)
                      && ({1'b0, item.now_ms} < st.ignore_wrap_until);
    assign check_due   = since_check > ext16(cfg.check_period_ms);
    assign over        = (diff > ext16(cfg.drift_limit_ms))
                      || (diff < -ext16(cfg.drift_limit_ms));
    assign cool        = (diff > ext16(cfg.large_drift_ms)) ? cfg.long_cooldown_ms
                                                            : cfg.seek_cooldown_ms;
    assign cooling     = since_corr <= ext16(cool);
    assign end_zone    = (item.duration_ms > 32'sd0)
                      && ($signed({3'd0, pts_c}) > dur_s - ext16(cfg.near_end_margin_ms));
    assign target      = $signed({1'b0, item.audio_clock_ms})
                       - $signed({16'd0, cfg.seek_back_ms});

    always_comb
    begin
        res     = '0;
        st_next = st;
        st_we   = 1'b0;
        if (item.channel_active && in_range)
        begin
            if (item.cmd == CMD_FINISHED)
            begin
                st_we                     = 1'b1;
                st_next.prev_pts          = 32'd0;
                st_next.last_check_time   = item.now_ms;
                st_next.initial_sync_done = 1'b0;
                st_next.video_paused      = 1'b0;
                st_next.ignore_wrap_until = {1'b0, item.now_ms} + WRAP_IGNORE_MS;
                res.restart_audio         = 1'b1;
            end
            else if (item.audio_valid)
            begin
                st_we            = 1'b1;
                st_next.prev_pts = {1'b0, pts_c};
                if (st.video_paused && resume_ok)
                begin
                    res.resume_video     = 1'b1;
                    st_next.video_paused = 1'b0;
                end
                if (wrap)
                begin
                    if (!ign_active)
                    begin
                        res.restart_audio       = 1'b1;
                        st_next.last_check_time = item.now_ms;
                    end
                end
                else if (check_due)
                begin
                    if (!st.initial_sync_done)
                    begin
                        res.seek_video            = 1'b1;
                        res.seek_target_ms        = target;
                        st_next.initial_sync_done = 1'b1;
                        st_next.last_correct_time = item.now_ms;
                        st_next.last_check_time   = item.now_ms;
                    end
                    else if (!over)
                    begin
                        st_next.last_check_time = item.now_ms;
                    end
                    else if (!cooling)
                    begin
                        if (!diff[33] && (diff != 34'sd0) && !end_zone)
                        begin
                            res.seek_video            = 1'b1;
                            res.seek_target_ms        = target;
                            st_next.last_correct_time = item.now_ms;
                        end
                        else if (diff[33] && !st_next.video_paused)
                        begin
                            res.pause_video           = 1'b1;
                            st_next.video_paused      = 1'b1;
                            st_next.last_correct_time = item.now_ms;
                        end
                        st_next.last_check_time = item.now_ms;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/av_sync_controller_core.sv
// Audio/video sync decision block, one decision per item.
// in_ch carries items: a sync tick or a playback-finished event for one channel,
// with the current time, audio clock, video timestamp and duration.
// out_ch carries exactly one result per item: resume, pause, seek with target,
// restart audio. Ignored items still give an all-zero result.
// The APB port sets the eight 16-bit thresholds and timings at byte address 4*i;
// write them only while no item is in flight.
// An accepted item is held in the input register until its result is registered.
// Throughput: one item per cycle while results are taken, set by the single
// decision stage between the input register and the result register; channel
// state is written as the item leaves the input register, so the next item sees it.
// A stalled receiver holds the result; one more item waits in the input register,
// then ready drops until the result is taken.
// Reset clears all channel state, restores register defaults and empties both
// stages.
`default_nettype none

`include "assert_macros.svh"

module av_sync_controller_core
    import avs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    avs_in_if.sink                 in_ch,
    avs_out_if.source              out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    avs_cfg_t    cfg;
    avs_item_t   item_in;
    avs_item_t   item_reg;
    avs_item_t   item_next;
    logic        in_vld_reg;
    logic        in_vld_next;
    avs_result_t res_reg;
    avs_result_t res_next;
    logic        out_vld_reg;
    logic        out_vld_next;
    avs_result_t res_comb;
    avs_chan_t   st_rd;
    avs_chan_t   st_wr;
    logic        st_we;
    logic        advance;
    logic        take;

    avs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    avs_state_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .channel  (item_reg.channel),
        .rd_state (st_rd),
        .wr_en    (st_we && advance),
        .wr_state (st_wr)
    );

    avs_decide u_decide (
        .item    (item_reg),
        .st      (st_rd),
        .cfg     (cfg),
        .res     (res_comb),
        .st_next (st_wr),
        .st_we   (st_we)
    );

    always_comb
    begin
        item_in.cmd            = in_ch.cmd;
        item_in.channel        = in_ch.channel;
        item_in.channel_active = in_ch.channel_active;
        item_in.now_ms         = in_ch.now_ms;
        item_in.audio_valid    = in_ch.audio_valid;
        item_in.audio_clock_ms = in_ch.audio_clock_ms;
        item_in.frame_pts_ms   = in_ch.frame_pts_ms;
        item_in.duration_ms    = in_ch.duration_ms;
    end

    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_vld_next  = take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        item_next    = take ? item_in : item_reg;
        out_vld_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_reg);
        res_next     = advance ? res_comb : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.resume_video   = res_reg.resume_video;
    assign out_ch.pause_video    = res_reg.pause_video;
    assign out_ch.seek_video     = res_reg.seek_video;
    assign out_ch.seek_target_ms = res_reg.seek_target_ms;
    assign out_ch.restart_audio  = res_reg.restart_audio;

    `AVS_ASSERT_NOW(a_seek_no_restart, out_vld_reg, !(res_reg.seek_video && res_reg.restart_audio))
    `AVS_ASSERT_NOW(a_target_only_seek, out_vld_reg && !res_reg.seek_video, res_reg.seek_target_ms == 32'sd0)
    `AVS_ASSERT_NOW(a_pause_no_seek, out_vld_reg, !(res_reg.pause_video && res_reg.seek_video))
    `AVS_ASSERT_NEXT(a_take_fills_stage, take, in_vld_reg)

endmodule

`default_nettype wire

>>> sim/av_sync_controller_core_test.sv
`timescale 1ns / 100ps

module av_sync_controller_core_test;
    import avs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int CFG_BITS = $bits(avs_cfg_t);

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    avs_in_if  in_ch();
    avs_out_if out_ch();

    av_sync_controller_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    avs_chan_t   chan_state [CHANNELS];
    logic [15:0] cfg_regs [8];
    avs_result_t pending_decisions [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          src_gaps = 1'b0;
    bit          sink_stalls = 1'b0;
    int          hold_off_req = 0;
    logic [31:0] clock_ms;
    int unsigned audio_pos [CHANNELS];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic avs_result_t predict_decision(avs_item_t it);
        avs_result_t r;
        int          c;
        longint      nowl;
        longint      audio;
        longint      pts;
        longint      dur;
        longint      diff;
        longint      thr;
        longint      cool;
        longint      target;
        logic        resume;
        logic        pause;
        logic        seek;
        logic        restart;
        logic        checked;
        logic        end_zone;
        r = '0;
        resume = 1'b0;
        pause = 1'b0;
        seek = 1'b0;
        restart = 1'b0;
        target = 0;
        if (!it.channel_active || int'(it.channel) >= CHANNELS)
            return r;
        c = it.channel;
        nowl = longint'(it.now_ms);
        if (it.cmd == CMD_FINISHED)
        begin
            chan_state[c].prev_pts = '0;
            chan_state[c].last_check_time = it.now_ms;
            chan_state[c].initial_sync_done = 1'b0;
            chan_state[c].video_paused = 1'b0;
            chan_state[c].ignore_wrap_until = {1'b0, it.now_ms} + WRAP_IGNORE_MS;
            r.restart_audio = 1'b1;
            return r;
        end
        if (!it.audio_valid)
            return r;
        audio = longint'(it.audio_clock_ms);
        pts = longint'($signed(it.frame_pts_ms));
        dur = longint'($signed(it.duration_ms));
        if (pts < 0)
            pts = 0;
        diff = audio - pts;
        thr = longint'(cfg_regs[REG_SYNC_THRESHOLD]);
        if (chan_state[c].video_paused && diff >= -longint'(cfg_regs[REG_RESUME_MARGIN]))
        begin
            resume = 1'b1;
            chan_state[c].video_paused = 1'b0;
        end
        if (chan_state[c].prev_pts > WRAP_PREV_MIN && pts < longint'(WRAP_PTS_MAX))
        begin
            if (!(chan_state[c].ignore_wrap_until != '0 &&
                  {1'b0, it.now_ms} < chan_state[c].ignore_wrap_until))
            begin
                restart = 1'b1;
                chan_state[c].last_check_time = it.now_ms;
            end
            chan_state[c].prev_pts = pts[31:0];
        end
        else
        begin
            if (nowl - longint'(chan_state[c].last_check_time) >
                longint'(cfg_regs[REG_CHECK_PERIOD]))
            begin
                checked = 1'b1;
                if (!chan_state[c].initial_sync_done)
                begin
                    seek = 1'b1;
                    target = audio - longint'(cfg_regs[REG_SEEK_BACK]);
                    chan_state[c].initial_sync_done = 1'b1;
                    chan_state[c].last_correct_time = it.now_ms;
                end
                else if (diff > thr || diff < -thr)
                begin
                    cool = (diff > longint'(cfg_regs[REG_LARGE_DRIFT])) ?
                           longint'(cfg_regs[REG_LONG_COOLDOWN]) :
                           longint'(cfg_regs[REG_SEEK_COOLDOWN]);
                    if (nowl - longint'(chan_state[c].last_correct_time) <= cool)
                        checked = 1'b0;
                    else
                    begin
                        end_zone = dur > 0 && pts > dur - longint'(cfg_regs[REG_NEAR_END]);
                        if (diff > 0 && !end_zone)
                        begin
                            seek = 1'b1;
                            target = audio - longint'(cfg_regs[REG_SEEK_BACK]);
                            chan_state[c].last_correct_time = it.now_ms;
                        end
                        else if (diff < 0 && !chan_state[c].video_paused)
                        begin
                            pause = 1'b1;
                            chan_state[c].video_paused = 1'b1;
                            chan_state[c].last_correct_time = it.now_ms;
                        end
                    end
                end
                if (checked)
                    chan_state[c].last_check_time = it.now_ms;
            end
            chan_state[c].prev_pts = pts[31:0];
        end
        r.resume_video = resume;
        r.pause_video = pause;
        r.seek_video = seek;
        r.seek_target_ms = seek ? target[31:0] : '0;
        r.restart_audio = restart;
        return r;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req > 0)
            begin
                stall_left = hold_off_req;
                hold_off_req = 0;
            end
            else if (stall_left == 0 && sink_stalls && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        avs_result_t got;
        avs_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{resume_video:   out_ch.resume_video,
                    pause_video:    out_ch.pause_video,
                    seek_video:     out_ch.seek_video,
                    seek_target_ms: out_ch.seek_target_ms,
                    restart_audio:  out_ch.restart_audio};
            if (pending_decisions.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                want = pending_decisions.pop_front();
                if (got !== want)
                    report_mismatch($sformatf({"expected resume %0b pause %0b seek %0b ",
                        "target %0d restart %0b, got resume %0b pause %0b seek %0b ",
                        "target %0d restart %0b"},
                        want.resume_video, want.pause_video, want.seek_video,
                        want.seek_target_ms, want.restart_audio,
                        got.resume_video, got.pause_video, got.seek_video,
                        got.seek_target_ms, got.restart_audio));
            end
        end
    end

    task automatic send_item(avs_item_t it);
        if (src_gaps && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= it.cmd;
        in_ch.channel        <= it.channel;
        in_ch.channel_active <= it.channel_active;
        in_ch.now_ms         <= it.now_ms;
        in_ch.audio_valid    <= it.audio_valid;
        in_ch.audio_clock_ms <= it.audio_clock_ms;
        in_ch.frame_pts_ms   <= it.frame_pts_ms;
        in_ch.duration_ms    <= it.duration_ms;
        do @(posedge clk); while (!in_ch.ready);
        pending_decisions.push_back(predict_decision(it));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_regs[idx] = val;
        @(posedge clk);
    endtask

    task automatic cfg_check(logic [CFG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== cfg_regs[idx])
            report_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                      idx, prdata[15:0], cfg_regs[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_registers(avs_cfg_t setting);
        for (int i = 0; i < 8; i++)
            cfg_write(CFG_IDX_W'(i), setting[CFG_BITS-1-16*i -: 16]);
        for (int i = 0; i < 8; i++)
            cfg_check(CFG_IDX_W'(i));
    endtask

    function automatic avs_item_t make_item(logic cmd, logic [1:0] ch, logic active,
                                            logic [31:0] now, logic av, logic [30:0] audio,
                                            logic [31:0] pts, logic [31:0] dur);
        avs_item_t it;
        it.cmd = cmd;
        it.channel = ch;
        it.channel_active = active;
        it.now_ms = now;
        it.audio_valid = av;
        it.audio_clock_ms = audio;
        it.frame_pts_ms = pts;
        it.duration_ms = dur;
        return it;
    endfunction

    // mostly plausible ticks on an advancing clock, some finishes, ignored items and noise
    task automatic send_stream_item();
        avs_item_t it;
        int        ch;
        int        sel;
        longint    pts;
        longint    dur;
        ch = $urandom_range(0, CHANNELS - 1);
        sel = $urandom_range(0, 99);
        clock_ms += $urandom_range(0, 120);
        audio_pos[ch] += $urandom_range(0, 120);
        pts = longint'(audio_pos[ch]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: pts = pts + $urandom_range(0, 600) - 300;
            5, 6: pts = pts + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(300, 3000);
            7: pts = pts + $urandom_range(0, 200000) - 100000;
            8: pts = $urandom_range(0, 99);
            default: pts = -longint'($urandom_range(1, 5000));
        endcase
        case ($urandom_range(0, 3))
            0: dur = 0;
            1: dur = -longint'($urandom_range(1, 100000));
            default: dur = pts + $urandom_range(0, 20000);
        endcase
        it = make_item(CMD_TICK, 2'(ch), 1'b1, clock_ms, 1'b1, 31'(audio_pos[ch]),
                       pts[31:0], dur[31:0]);
        if (sel < 6)
        begin
            it.cmd = CMD_FINISHED;
            it.audio_valid = 1'($urandom);
            audio_pos[ch] = $urandom_range(0, 500);
        end
        else if (sel < 12)
        begin
            it.channel_active = 1'($urandom);
            it.audio_valid = 1'b0;
        end
        else if (sel < 16)
            it = make_item(1'($urandom), 2'($urandom), 1'($urandom), $urandom,
                           1'($urandom), 31'($urandom), $urandom, $urandom);
        send_item(it);
    endtask

    task automatic run_stream(int n);
        repeat (n) send_stream_item();
        wait_idle();
    endtask

    task automatic test_reset_values();
        for (int i = 0; i < 8; i++)
            cfg_check(CFG_IDX_W'(i));
    endtask

    task automatic test_directed_cases();
        send_item(make_item(CMD_TICK, 3, 0, '1, 1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(CMD_TICK, 3, 1, 50, 0, 1234, 10, 0));
        send_item(make_item(CMD_TICK, 0, 1, 100, 1, 5000, 5000, 0));
        send_item(make_item(CMD_TICK, 0, 1, 110, 1, 5100, 6000, 0));
        send_item(make_item(CMD_TICK, 0, 1, 200, 1, 5200, 5100, 0));
        send_item(make_item(CMD_TICK, 0, 1, 500, 1, 8000, 5300, 0));
        send_item(make_item(CMD_TICK, 0, 1, 1400, 1, 8000, 5300, 0));
        send_item(make_item(CMD_TICK, 0, 1, 1800, 1, 8000, 9000, 0));
        send_item(make_item(CMD_TICK, 0, 1, 1900, 1, 9000, 9050, 0));
        send_item(make_item(CMD_TICK, 0, 1, 3000, 1, 20000, 15000, 20000));
        send_item(make_item(CMD_TICK, 0, 1, 3100, 1, 20000, 15000, 20000));
        send_item(make_item(CMD_TICK, 0, 1, 3200, 1, 20000, 50, 0));
        send_item(make_item(CMD_FINISHED, 0, 1, 3300, 0, 0, 0, 0));
        send_item(make_item(CMD_TICK, 0, 1, 3400, 1, 5000, 5000, 0));
        send_item(make_item(CMD_TICK, 0, 1, 3500, 1, 5100, 10, 0));
        send_item(make_item(CMD_FINISHED, 1, 0, 3600, 1, 0, 0, 0));
        send_item(make_item(CMD_TICK, 1, 1, 3700, 1, 0, 32'h8000_0000, 32'h8000_0000));
        send_item(make_item(CMD_TICK, 1, 1, 4000, 1, 5000, 4000, -32'sd5));
        send_item(make_item(CMD_TICK, 1, 1, 4100, 1, 5000, 4000, -32'sd5));
        send_item(make_item(CMD_TICK, 2, 1, '1, 1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(CMD_TICK, 2, 1, 0, 1, '1, 0, 0));
        send_item(make_item(CMD_FINISHED, 2, 1, '1, 1, 0, 0, 0));
        send_item(make_item(CMD_TICK, 2, 1, '1, 1, 5000, 1500, 0));
        send_item(make_item(CMD_TICK, 2, 1, '1, 1, 5000, 20, 0));
        clock_ms = 5000;
        wait_idle();
    endtask

    task automatic test_register_settings();
        avs_cfg_t s;
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        program_registers('0);
        run_stream(80);
        program_registers('1);
        run_stream(80);
        s = {$urandom, $urandom, $urandom, $urandom};
        program_registers(s);
        run_stream(80);
        for (int i = 0; i < 8; i++)
            s[CFG_BITS-1-16*i -: 16] = $urandom_range(0, 3000);
        program_registers(s);
        run_stream(80);
    endtask

    task automatic test_resume_then_pause();
        avs_cfg_t s;
        s = CFG_RESET;
        s.drift_limit_ms = '0;
        s.resume_margin_ms = '1;
        s.check_period_ms = '0;
        s.seek_cooldown_ms = '0;
        s.long_cooldown_ms = '0;
        program_registers(s);
        send_item(make_item(CMD_FINISHED, 3, 1, clock_ms + 1, 1, 0, 0, 0));
        send_item(make_item(CMD_TICK, 3, 1, clock_ms + 2, 1, 1000, 1000, 0));
        send_item(make_item(CMD_TICK, 3, 1, clock_ms + 3, 1, 1000, 1200, 0));
        send_item(make_item(CMD_TICK, 3, 1, clock_ms + 4, 1, 1000, 1010, 0));
        clock_ms += 10;
        run_stream(60);
        program_registers(CFG_RESET);
    endtask

    task automatic test_backpressure();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_off_req = 150;
        @(posedge clk);
        run_stream(40);
    endtask

    task automatic test_random_traffic();
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        run_stream(400);
    endtask

    task automatic test_steady_traffic();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        clock_ms = 32'hFFFF_F000;
        run_stream(100);
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.cmd            <= CMD_TICK;
        in_ch.channel        <= '0;
        in_ch.channel_active <= 1'b0;
        in_ch.now_ms         <= '0;
        in_ch.audio_valid    <= 1'b0;
        in_ch.audio_clock_ms <= '0;
        in_ch.frame_pts_ms   <= '0;
        in_ch.duration_ms    <= '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_state[c] = '0;
            audio_pos[c] = $urandom_range(0, 20000);
        end
        for (int i = 0; i < 8; i++)
            cfg_regs[i] = CFG_RESET[CFG_BITS-1-16*i -: 16];
        clock_ms = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_cases();
        test_register_settings();
        test_resume_then_pause();
        test_backpressure();
        test_random_traffic();
        test_steady_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
